// ----- src/tcpg_pkg.sv -----
// ----------------------------------------------------------------------------
// tcpg_pkg: shared types and constants of the text character pixel generator
// Glyph index coding, scanner state, job and pixel records, register indexes.
// ----------------------------------------------------------------------------
package tcpg_pkg;

  // screen sides above this are clamped
  localparam logic [8:0] MAX_SIDE      = 9'd256;
  // pen step per drawn character
  localparam int         GLYPH_ADVANCE = 6;

  // glyph cell grid, column-major scan
  localparam logic [2:0] COL_LAST = 3'd4;
  localparam logic [2:0] ROW_LAST = 3'd6;
  localparam int         GLYPH_BITS = 35;

  // configuration register indexes
  localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RIGHT_LIMIT   = 2'd2;

  // glyph rom indexes
  localparam logic [5:0] GLYPH_BLANK  = 6'd0;
  localparam logic [5:0] GLYPH_DIGIT0 = 6'd1;
  localparam logic [5:0] GLYPH_LETA   = 6'd11;
  localparam logic [5:0] GLYPH_DASH   = 6'd37;
  localparam logic [5:0] GLYPH_COLON  = 6'd38;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_CELLS,
    SCAN_FLUSH
  } tcpg_scan_state_t;

  // one drawing request handed to the scanner
  typedef struct packed {
    logic signed [9:0] x0;
    logic signed [9:0] y0;
    logic [15:0]       color;
  } tcpg_job_t;

  // one pixel write, x in the lowest bits
  typedef struct packed {
    logic [15:0] value;
    logic [15:0] address;
    logic [7:0]  y;
    logic [7:0]  x;
  } tcpg_pix_t;

  // map a character byte to its glyph rom entry, lower case folded
  function automatic logic [5:0] glyph_index(input logic [7:0] code);
    logic [7:0] up;
    logic [5:0] idx;
    up  = code;
    idx = GLYPH_BLANK;
    if (code >= 8'h61 && code <= 8'h7a) up = code - 8'd32;
    if (code >= 8'h30 && code <= 8'h39) begin
      idx = GLYPH_DIGIT0 + 6'(code - 8'h30);
    end else if (up >= 8'h41 && up <= 8'h5a) begin
      idx = GLYPH_LETA + 6'(up - 8'h41);
    end else if (code == 8'h2d) begin
      idx = GLYPH_DASH;
    end else if (code == 8'h3a) begin
      idx = GLYPH_COLON;
    end
    return idx;
  endfunction

endpackage

// ----- src/tcpg_font_rom.sv -----
// ----------------------------------------------------------------------------
// tcpg_font_rom: 5x7 column font rom
// Synchronous registered read; data holds until the next read.
// Column c of the glyph sits in bits [7c+6:7c], row 0 in the low bit.
// ----------------------------------------------------------------------------
module tcpg_font_rom (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [5:0]                    rd_index,
  output logic [tcpg_pkg::GLYPH_BITS-1:0] rd_data
);
  import tcpg_pkg::*;

  // pack five columns, first column lowest
  function automatic logic [GLYPH_BITS-1:0] cols5(input logic [6:0] c0, input logic [6:0] c1,
                                                  input logic [6:0] c2, input logic [6:0] c3,
                                                  input logic [6:0] c4);
    return {c4, c3, c2, c1, c0};
  endfunction

  function automatic logic [GLYPH_BITS-1:0] font(input logic [5:0] idx);
    logic [GLYPH_BITS-1:0] g;
    case (idx)
      6'd1:  g = cols5(7'h3e, 7'h51, 7'h49, 7'h45, 7'h3e);
      6'd2:  g = cols5(7'h00, 7'h42, 7'h7f, 7'h40, 7'h00);
      6'd3:  g = cols5(7'h42, 7'h61, 7'h51, 7'h49, 7'h46);
      6'd4:  g = cols5(7'h21, 7'h41, 7'h45, 7'h4b, 7'h31);
      6'd5:  g = cols5(7'h18, 7'h14, 7'h12, 7'h7f, 7'h10);
      6'd6:  g = cols5(7'h27, 7'h45, 7'h45, 7'h45, 7'h39);
      6'd7:  g = cols5(7'h3c, 7'h4a, 7'h49, 7'h49, 7'h30);
      6'd8:  g = cols5(7'h01, 7'h71, 7'h09, 7'h05, 7'h03);
      6'd9:  g = cols5(7'h36, 7'h49, 7'h49, 7'h49, 7'h36);
      6'd10: g = cols5(7'h06, 7'h49, 7'h49, 7'h29, 7'h1e);
      6'd11: g = cols5(7'h7e, 7'h11, 7'h11, 7'h11, 7'h7e);
      6'd12: g = cols5(7'h7f, 7'h49, 7'h49, 7'h49, 7'h36);
      6'd13: g = cols5(7'h3e, 7'h41, 7'h41, 7'h41, 7'h22);
      6'd14: g = cols5(7'h7f, 7'h41, 7'h41, 7'h22, 7'h1c);
      6'd15: g = cols5(7'h7f, 7'h49, 7'h49, 7'h49, 7'h41);
      6'd16: g = cols5(7'h7f, 7'h09, 7'h09, 7'h09, 7'h01);
      6'd17: g = cols5(7'h3e, 7'h41, 7'h49, 7'h49, 7'h7a);
      6'd18: g = cols5(7'h7f, 7'h08, 7'h08, 7'h08, 7'h7f);
      6'd19: g = cols5(7'h00, 7'h41, 7'h7f, 7'h41, 7'h00);
      6'd20: g = cols5(7'h20, 7'h40, 7'h41, 7'h3f, 7'h01);
      6'd21: g = cols5(7'h7f, 7'h08, 7'h14, 7'h22, 7'h41);
      6'd22: g = cols5(7'h7f, 7'h40, 7'h40, 7'h40, 7'h40);
      6'd23: g = cols5(7'h7f, 7'h02, 7'h0c, 7'h02, 7'h7f);
      6'd24: g = cols5(7'h7f, 7'h04, 7'h08, 7'h10, 7'h7f);
      6'd25: g = cols5(7'h3e, 7'h41, 7'h41, 7'h41, 7'h3e);
      6'd26: g = cols5(7'h7f, 7'h09, 7'h09, 7'h09, 7'h06);
      6'd27: g = cols5(7'h3e, 7'h41, 7'h51, 7'h21, 7'h5e);
      6'd28: g = cols5(7'h7f, 7'h09, 7'h19, 7'h29, 7'h46);
      6'd29: g = cols5(7'h46, 7'h49, 7'h49, 7'h49, 7'h31);
      6'd30: g = cols5(7'h01, 7'h01, 7'h7f, 7'h01, 7'h01);
      6'd31: g = cols5(7'h3f, 7'h40, 7'h40, 7'h40, 7'h3f);
      6'd32: g = cols5(7'h1f, 7'h20, 7'h40, 7'h20, 7'h1f);
      6'd33: g = cols5(7'h3f, 7'h40, 7'h38, 7'h40, 7'h3f);
      6'd34: g = cols5(7'h63, 7'h14, 7'h08, 7'h14, 7'h63);
      6'd35: g = cols5(7'h07, 7'h08, 7'h70, 7'h08, 7'h07);
      6'd36: g = cols5(7'h61, 7'h51, 7'h49, 7'h45, 7'h43);
      6'd37: g = cols5(7'h08, 7'h08, 7'h08, 7'h08, 7'h08);
      6'd38: g = cols5(7'h00, 7'h00, 7'h36, 7'h00, 7'h00);
      default: g = '0;
    endcase
    return g;
  endfunction

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= font(rd_index);
    end
  end

endmodule

// ----- src/tcpg_scan.sv -----
// ----------------------------------------------------------------------------
// tcpg_scan: glyph cell scanner and pixel output stage
// Walks the 35 glyph cells one a cycle unless stalled, clips to the screen,
// holds one pixel back so the final write of a character can carry tlast.
// ----------------------------------------------------------------------------
module tcpg_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  tcpg_pkg::tcpg_job_t           job,
  input  logic [tcpg_pkg::GLYPH_BITS-1:0] glyph,
  input  logic [8:0]                    side_w,
  input  logic [8:0]                    side_h,
  output logic                          busy,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [47:0]                   m_tdata,   // pix_x, pix_y, pix_address, pix_value
  output logic                          m_tlast    // last_pixel
);
  import tcpg_pkg::*;

  tcpg_scan_state_t state, state_next;
  logic [2:0]        col;
  logic [2:0]        row;
  tcpg_job_t         cur;
  logic              hold_valid;
  tcpg_pix_t         hold;
  tcpg_pix_t         out_pix;

  logic [6:0]  col_bits;
  logic        cell_set;
  logic [10:0] x_sum;
  logic [10:0] y_sum;
  logic        visible;
  logic [16:0] addr_full;
  tcpg_pix_t   cell_pix;
  logic        out_free;
  logic        advance;
  logic        out_load;
  logic        last_cell;

  // current column of the glyph
  always_comb begin
    case (col)
      3'd0:    col_bits = glyph[6:0];
      3'd1:    col_bits = glyph[13:7];
      3'd2:    col_bits = glyph[20:14];
      3'd3:    col_bits = glyph[27:21];
      3'd4:    col_bits = glyph[34:28];
      default: col_bits = '0;
    endcase
  end

  // cell position, clipping and frame-buffer address
  always_comb begin
    cell_set  = col_bits[row];
    x_sum     = {cur.x0[9], cur.x0} + {8'd0, col};
    y_sum     = {cur.y0[9], cur.y0} + {8'd0, row};
    visible   = cell_set && !x_sum[10] && !y_sum[10]
                && (x_sum[9:0] < {1'b0, side_w}) && (y_sum[9:0] < {1'b0, side_h});
    addr_full = {9'd0, y_sum[7:0]} * {8'd0, side_w} + {9'd0, x_sum[7:0]};
    cell_pix.x       = x_sum[7:0];
    cell_pix.y       = y_sum[7:0];
    cell_pix.address = addr_full[15:0];
    cell_pix.value   = {cur.color[7:0], cur.color[15:8]};
  end

  // scan control
  always_comb begin
    out_free  = !m_tvalid || m_tready;
    last_cell = (col == COL_LAST) && (row == ROW_LAST);
    advance   = (state == SCAN_CELLS) && !(visible && hold_valid && !out_free);
    out_load  = ((state == SCAN_CELLS) && visible && hold_valid && out_free)
                || ((state == SCAN_FLUSH) && hold_valid && out_free);
    busy      = (state != SCAN_IDLE);
    state_next = state;
    unique case (state)
      SCAN_IDLE:  if (start) state_next = SCAN_CELLS;
      SCAN_CELLS: if (advance && last_cell) state_next = SCAN_FLUSH;
      SCAN_FLUSH: if (!hold_valid || out_free) state_next = SCAN_IDLE;
      default:    state_next = SCAN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCAN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // cell counters and job capture
  always_ff @(posedge clk) begin
    if (start && state == SCAN_IDLE) begin
      cur <= job;
      col <= '0;
      row <= '0;
    end else if (advance) begin
      if (row == ROW_LAST) begin
        row <= '0;
        col <= col + 3'd1;
      end else begin
        row <= row + 3'd1;
      end
    end
  end

  // one-deep hold of the latest visible pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (advance && visible) begin
      hold_valid <= 1'b1;
    end else if (state == SCAN_FLUSH && out_load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && visible) begin
      hold <= cell_pix;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pix <= hold;
      m_tlast <= (state == SCAN_FLUSH);
    end
  end

  assign m_tdata = out_pix;

endmodule

// ----- src/text_character_pixel_generator.sv -----
// ----------------------------------------------------------------------------
// text_character_pixel_generator: bitmap font text to pixel writes
// Turns character codes into RGB565 frame-buffer pixel writes, 5x7 font.
// ----------------------------------------------------------------------------
// A drawn character goes through the accepted request, which also reads the
// glyph rom, the scanner's walk over all 35 glyph cells, and the release of
// the held final pixel with tlast; a stalled output holds it up. A request
// that draws nothing (zero code, ended string, pen at or past right_limit)
// starts no scan. The next request is taken as soon as the scanner is idle,
// while the last pixel may still wait in the output register. Configuration
// writes are always ready and are to be made only while no character is in
// flight.
module text_character_pixel_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // char_code, start_x, start_y, ink_color, zero fill
  input  logic        s_tuser,   // first_of_string
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // pix_x, pix_y, pix_address, pix_value
  output logic        m_tlast,   // last_pixel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import tcpg_pkg::*;

  logic [8:0] screen_width;
  logic [8:0] screen_height;
  logic [8:0] right_limit;
  logic [8:0] side_w;
  logic [8:0] side_h;

  logic signed [9:0] pen_x, pen_x_next;
  logic signed [9:0] pen_y, pen_y_next;
  logic              string_ended, string_ended_next;

  logic [7:0]        char_code;
  logic signed [9:0] start_x;
  logic signed [9:0] start_y;
  logic [15:0]       ink_color;

  logic              s_accept;
  logic signed [9:0] pen_x_eff;
  logic signed [9:0] pen_y_eff;
  logic              ended_eff;
  logic [10:0]       adv_sum;
  logic              scan_start;
  logic              scan_busy;
  tcpg_job_t         job;
  logic [GLYPH_BITS-1:0] glyph;

  // input fields
  assign char_code = s_tdata[7:0];
  assign start_x   = s_tdata[17:8];
  assign start_y   = s_tdata[27:18];
  assign ink_color = s_tdata[43:28];

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 9'd240;
      screen_height <= 9'd240;
      right_limit   <= 9'd235;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        CFG_RIGHT_LIMIT:   right_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign side_w = (screen_width > MAX_SIDE) ? MAX_SIDE : screen_width;
  assign side_h = (screen_height > MAX_SIDE) ? MAX_SIDE : screen_height;

  // request decode and pen update
  always_comb begin
    s_tready   = !scan_busy;
    s_accept   = s_tvalid && s_tready;
    pen_x_eff  = s_tuser ? start_x : pen_x;
    pen_y_eff  = s_tuser ? start_y : pen_y;
    ended_eff  = s_tuser ? 1'b0 : string_ended;
    adv_sum    = {pen_x_eff[9], pen_x_eff} + 11'(GLYPH_ADVANCE);
    scan_start = 1'b0;
    pen_x_next = pen_x;
    pen_y_next = pen_y;
    string_ended_next = string_ended;
    if (s_accept) begin
      pen_x_next = pen_x_eff;
      pen_y_next = pen_y_eff;
      string_ended_next = ended_eff;
      if (char_code == 8'd0) begin
        string_ended_next = 1'b1;
      end else if (!ended_eff) begin
        if (pen_x_eff >= $signed({1'b0, right_limit})) begin
          string_ended_next = 1'b1;
        end else begin
          scan_start = 1'b1;
          // pen saturates at the top of its range
          pen_x_next = (!adv_sum[10] && adv_sum[9]) ? 10'sd511 : adv_sum[9:0];
        end
      end
    end
    job.x0    = pen_x_eff;
    job.y0    = pen_y_eff;
    job.color = ink_color;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x        <= '0;
      pen_y        <= '0;
      string_ended <= 1'b1;
    end else begin
      pen_x        <= pen_x_next;
      pen_y        <= pen_y_next;
      string_ended <= string_ended_next;
    end
  end

  // glyph rom, read in the request cycle
  tcpg_font_rom u_font_rom (
    .clk      (clk),
    .rd_en    (scan_start),
    .rd_index (glyph_index(char_code)),
    .rd_data  (glyph)
  );

  // cell scanner and pixel output
  tcpg_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (scan_start),
    .job      (job),
    .glyph    (glyph),
    .side_w   (side_w),
    .side_h   (side_h),
    .busy     (scan_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // checks
  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    scan_start |-> !scan_busy)
    else $error("scan started while scanner busy");

  a_busy_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(scan_busy) |-> $past(s_accept))
    else $error("scanner went busy without an accepted request");

  a_pen_moves_on: assert property (@(posedge clk) disable iff (rst)
    scan_start |=> (pen_x > $past(pen_x_eff)))
    else $error("pen did not advance after a drawn character");

endmodule
